// File: rtl/elfbid_pkg.sv
`timescale 1ns / 1ps

package elfbid_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int SEG_LEN_W       = 16;
    localparam int HDR_BYTES       = 12;
    localparam int NAME_END        = 16;
    localparam int NOTE_END_W      = 35;

    localparam logic KIND_HEX  = 1'b0;
    localparam logic KIND_NONE = 1'b1;

    localparam logic [31:0] BUILD_ID_TYPE = 32'd3;
    localparam logic [31:0] GNU_NAME_SIZE = 32'd4;

    typedef struct packed {
        logic       kind;
        logic [7:0] hex_char;
        logic       last;
    } result_t;

    // Up to two results come out of one request.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } scan_res_t;

    localparam result_t NOT_FOUND = '{kind: KIND_NONE, hex_char: 8'h00, last: 1'b1};

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h57 + {4'h0, nib};
        end
        return ch;
    endfunction

    function automatic logic [7:0] gnu_byte(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0: ch = 8'h47;
            2'd1: ch = 8'h4e;
            2'd2: ch = 8'h55;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Rounds up to a multiple of four without wrapping.
    function automatic logic [32:0] pad4(input logic [31:0] n);
        logic [32:0] s;
        s = {1'b0, n} + 33'd3;
        return {s[32:2], 2'b00};
    endfunction

endpackage

// File: rtl/elfbid_scan.sv
`timescale 1ns / 1ps

module elfbid_scan #(
    parameter int LENGTH_BITS = elfbid_pkg::LENGTH_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               go,
    input  logic [7:0]                         data_byte,
    input  logic                               first_byte,
    input  logic [elfbid_pkg::SEG_LEN_W-1:0]   segment_length,
    output elfbid_pkg::scan_res_t              res
);
    import elfbid_pkg::*;

    localparam int LW  = LENGTH_BITS;
    localparam int NEW = NOTE_END_W;

    localparam logic [LW-1:0] K_DESC  = LW'(4);
    localparam logic [LW-1:0] K_TYPE  = LW'(8);
    localparam logic [LW-1:0] K_LAST  = LW'(HDR_BYTES - 1);
    localparam logic [LW-1:0] K_NAME  = LW'(HDR_BYTES);
    localparam logic [LW-1:0] K_DESC0 = LW'(NAME_END);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] begin_reg, begin_next;
    logic [31:0]   name_reg, name_next;
    logic [31:0]   desc_reg, desc_next;
    logic [31:0]   type_reg, type_next;
    logic          match_reg, match_next;

    logic            take;
    logic            start_note;
    logic [LW-1:0]   start_pos;
    logic [LW-1:0]   k;
    logic [LW-1:0]   idx;
    logic [NEW-1:0]  note_end;
    logic [31:0]     byte_word;
    logic            hex_emit;
    logic            fin;
    scan_res_t       res_c;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        begin_next = begin_reg;
        name_next  = name_reg;
        desc_next  = desc_reg;
        type_next  = type_reg;
        match_next = match_reg;
        res_c      = '0;
        take       = 1'b0;
        start_note = 1'b0;
        start_pos  = '0;
        k          = '0;
        idx        = '0;
        note_end   = '0;
        byte_word  = '0;
        hex_emit   = 1'b0;
        fin        = 1'b0;

        if (first_byte) begin
            len_next   = LW'(segment_length);
            pos_next   = '0;
            begin_next = '0;
            if ((LW + 1)'(HDR_BYTES) < {1'b0, len_next}) begin
                phase_next = PH_HEADER;
                name_next  = '0;
                desc_next  = '0;
                type_next  = '0;
                match_next = 1'b0;
                take       = 1'b1;
            end else begin
                phase_next   = PH_DONE;
                res_c.count  = 2'd1;
                res_c.r0     = NOT_FOUND;
            end
        end else if (phase_reg == PH_HEADER || phase_reg == PH_BODY) begin
            take = 1'b1;
        end

        if (take) begin
            k = pos_next - begin_next;
            if (phase_next == PH_HEADER) begin
                byte_word = 32'(data_byte) << {k[1:0], 3'b000};
                if (k < K_DESC) begin
                    name_next = name_next | byte_word;
                end else if (k < K_TYPE) begin
                    desc_next = desc_next | byte_word;
                end else begin
                    type_next = type_next | byte_word;
                end
                if (k >= K_LAST) begin
                    note_end = NEW'(begin_next) + NEW'(HDR_BYTES) + NEW'(pad4(name_next))
                             + NEW'(pad4(desc_next));
                    if (note_end > NEW'(len_next)) begin
                        phase_next  = PH_DONE;
                        res_c.count = 2'd1;
                        res_c.r0    = NOT_FOUND;
                    end else begin
                        match_next = (type_next == BUILD_ID_TYPE)
                                  && (name_next == GNU_NAME_SIZE) && (desc_next != 32'd0);
                        if (note_end == NEW'(pos_next) + NEW'(1)) begin
                            start_note = 1'b1;
                            start_pos  = note_end[LW-1:0];
                        end else begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end else begin
                if (match_reg) begin
                    if (k >= K_NAME && k < K_DESC0) begin
                        // Name offsets are aligned, so the low bits pick the character.
                        if (data_byte != gnu_byte(k[1:0])) begin
                            match_next = 1'b0;
                        end
                    end else if (k >= K_DESC0) begin
                        idx = k - K_DESC0;
                        if (33'(idx) < {1'b0, desc_next}) begin
                            hex_emit = 1'b1;
                            fin      = (33'(idx) + 33'd1) == {1'b0, desc_next};
                            res_c.count = 2'd2;
                            res_c.r0 = '{kind: KIND_HEX, hex_char: hex_digit(data_byte[7:4]),
                                         last: 1'b0};
                            res_c.r1 = '{kind: KIND_HEX, hex_char: hex_digit(data_byte[3:0]),
                                         last: fin};
                            if (fin) begin
                                phase_next = PH_DONE;
                            end
                        end
                    end
                end
                if (!hex_emit) begin
                    note_end = NEW'(begin_next) + NEW'(HDR_BYTES) + NEW'(pad4(name_next))
                             + NEW'(pad4(desc_next));
                    if (note_end == NEW'(pos_next) + NEW'(1)) begin
                        start_note = 1'b1;
                        start_pos  = note_end[LW-1:0];
                    end
                end
            end
            pos_next = pos_next + LW'(1);
        end

        if (start_note) begin
            begin_next = start_pos;
            if ({1'b0, start_pos} + (LW + 1)'(HDR_BYTES) < {1'b0, len_next}) begin
                phase_next = PH_HEADER;
                name_next  = '0;
                desc_next  = '0;
                type_next  = '0;
                match_next = 1'b0;
            end else begin
                phase_next  = PH_DONE;
                res_c.count = 2'd1;
                res_c.r0    = NOT_FOUND;
            end
        end

        if (!go) begin
            res_c.count = 2'd0;
        end
    end

    assign res = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            begin_reg <= '0;
            name_reg  <= '0;
            desc_reg  <= '0;
            type_reg  <= '0;
            match_reg <= 1'b0;
        end else if (go) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            begin_reg <= begin_next;
            name_reg  <= name_next;
            desc_reg  <= desc_next;
            type_reg  <= type_next;
            match_reg <= match_next;
        end
    end

    a_pair_is_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.count == 2'd2) |-> (res.r0.kind == KIND_HEX && !res.r0.last
                                 && res.r1.kind == KIND_HEX))
        else $error("two results from one request must both be hex digits");

    a_none_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.count != 2'd0 && res.r0.kind == KIND_NONE) |-> (res.count == 2'd1 && res.r0.last))
        else $error("not-found result must be single and final");

    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((res.count == 2'd1 && res.r0.last) || (res.count == 2'd2 && res.r1.last))
            |=> (phase_reg == PH_DONE))
        else $error("search must end after its final result");

    a_no_count_three: assert property (@(posedge aclk) disable iff (!aresetn)
        res.count != 2'd3)
        else $error("result count out of range");

endmodule

// File: rtl/elfbid_res_fifo.sv
`timescale 1ns / 1ps

module elfbid_res_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  elfbid_pkg::scan_res_t   push,
    output logic                    has_room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output elfbid_pkg::result_t     out_data
);
    import elfbid_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = PW + 1;

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for a full pair of results, whatever leaves this cycle.
    assign has_room  = count_reg <= CW'(DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.r1;
        end
    end

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("result queue over capacity");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (CW'(push.count) <= CW'(DEPTH) - count_reg))
        else $error("results pushed without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd0 && pop) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count lost track of a pop");

endmodule

// File: rtl/elf_build_id_note_scanner_top.sv
// Channel  Ports                                         Direction  Handshake
// input    s_data_byte, s_first_byte, s_segment_length   in         s_valid / s_ready
// result   m_result_kind, m_hex_char, m_last             out        m_valid / m_ready
//
// A request is registered on acceptance and scanned from that register once the
// result queue has room; its results reach the result channel through the queue.
// One request per cycle is taken while no build-id byte is being emitted and
// the queue has room; a descriptor byte yields two results, so the four-entry
// result queue and its single read port then hold off further requests.
// aresetn is synchronous and active low; it clears the scan state and the queue.
// A stall on m_ready fills the queue and then holds off s_ready.
`timescale 1ns / 1ps

module elf_build_id_note_scanner_top #(
    parameter int LENGTH_BITS = elfbid_pkg::LENGTH_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_first_byte,
    input  logic [elfbid_pkg::SEG_LEN_W-1:0]   s_segment_length,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_result_kind,
    output logic [7:0]                         m_hex_char,
    output logic                               m_last
);
    import elfbid_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           data_reg;
    logic                 first_reg;
    logic [SEG_LEN_W-1:0] seg_len_reg;
    logic                 has_room;
    logic                 go;
    scan_res_t            scan_res;
    result_t              out_data;

    assign go      = in_valid_reg && has_room;
    assign s_ready = !in_valid_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg    <= s_data_byte;
            first_reg   <= s_first_byte;
            seg_len_reg <= s_segment_length;
        end
    end

    elfbid_scan #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .go             (go),
        .data_byte      (data_reg),
        .first_byte     (first_reg),
        .segment_length (seg_len_reg),
        .res            (scan_res)
    );

    elfbid_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (scan_res),
        .has_room  (has_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_result_kind = out_data.kind;
    assign m_hex_char    = out_data.hex_char;
    assign m_last        = out_data.last;

endmodule
